FILE: sv/dnc_pkg.sv
// Package for the DNS name compressor: sizes, widths and the request and
// result payload types. No dependencies.
`timescale 1ns / 1ps

package dnc_pkg;

	localparam int MSG_BYTES      = 16384;
	localparam int SUFFIX_ENTRIES = 64;
	localparam int NAME_BYTES     = 255;
	localparam int STORE_DEPTH    = MSG_BYTES + 256;
	localparam int STORE_AW       = $clog2(STORE_DEPTH);
	localparam int SE_AW          = $clog2(SUFFIX_ENTRIES);
	localparam int SE_CW          = $clog2(SUFFIX_ENTRIES + 1);
	localparam int SUF_W          = 22;
	localparam logic [16:0] POINTER_LIMIT = 17'h03FFF;
	localparam logic [6:0]  HOP_LIMIT     = 7'd127;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
		logic       compress;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [63:0] out_bytes;
		logic [3:0]  out_count;
		logic        out_last;
		logic        out_matched;
	} result_t;

endpackage

FILE: sv/dnc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module dnc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/dnc_outreg.sv
// Output register slice for result items; holds a result until it is taken.
// Depends on dnc_pkg.
`timescale 1ns / 1ps

module dnc_outreg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  dnc_pkg::result_t load_data,
	output logic            free,
	output logic            valid,
	input  logic            stall,
	output dnc_pkg::result_t data
);

	logic            valid_q;
	dnc_pkg::result_t data_q;

	assign free  = !valid_q || !stall;
	assign valid = valid_q;
	assign data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			data_q  <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			data_q  <= load_data;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

endmodule

FILE: sv/dns_name_compressor.sv
// DNS message renderer with suffix compression. A raw byte's result is loaded into the
// output register as it is accepted, or from ST_RAW while that register is busy. A name
// byte without the last mark is stored. The last byte starts a search: each table entry
// tried is read, each compared byte is read from both sides and pointers are chased; then
// the name bytes are emitted and packed into results, and the labels are recorded. Reset
// clears the registers only; the memories need no clearing pass.
`timescale 1ns / 1ps

module dns_name_compressor (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  dnc_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output dnc_pkg::result_t result
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_RAW, ST_SR_RD, ST_SR_GET, ST_E_RD, ST_E_GET, ST_E_NEXT,
		ST_C_RD, ST_C_CHK, ST_C_PRD, ST_C_PGET, ST_SR_DONE, ST_EM_RD, ST_EM_GET,
		ST_FLUSH, ST_RC_RD, ST_RC_GET
	} state_t;

	function automatic logic [7:0] fold(input logic [7:0] b);
		fold = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
	endfunction

	state_t                       state_q;
	logic [15:0]                  msg_len_q;
	logic [8:0]                   name_cnt_q;
	logic [dnc_pkg::SE_CW-1:0]    tcount_q;
	logic [dnc_pkg::SE_CW-1:0]    e_q;
	logic [7:0]                   raw_q;
	logic                         cmp_q;
	logic                         found_q;
	logic [9:0]                   i_q;
	logic [7:0]                   lab_q;
	logic [13:0]                  ent_pos_q;
	logic [8:0]                   tgt_q;
	logic [8:0]                   kk_q;
	logic [15:0]                  pa_q;
	logic [15:0]                  pb_q;
	logic [7:0]                   la_q;
	logic [7:0]                   lb_q;
	logic                         sel_q;
	logic [6:0]                   hops_q;
	logic [5:0]                   ptrb_q;
	logic [7:0]                   ba_q;
	logic                         ok_q;
	logic [9:0]                   j_q;
	logic [8:0]                   k_q;
	logic [8:0]                   n_q;
	logic [8:0]                   end_q;
	logic [15:0]                  off_q;
	logic [63:0]                  word_q;
	logic [3:0]                   cnt_q;
	logic                         flast_q;

	logic                         accept;
	logic                         append;
	logic [7:0]                   append_byte;
	logic                         st_we;
	logic [7:0]                   st_rdata;
	logic [7:0]                   nm_rdata;
	logic                         nm_we;
	logic [7:0]                   nm_raddr;
	logic [dnc_pkg::SUF_W-1:0]    sf_rdata;
	logic                         sf_we;
	logic [dnc_pkg::SUF_W-1:0]    sf_wdata;
	logic [15:0]                  cur_pos;
	logic [16:0]                  cur_addr;
	logic                         ok_d;
	logic [7:0]                   rd_byte;
	logic [7:0]                   cur_llen;
	logic [7:0]                   em_byte;
	logic [9:0]                   skip_i;
	logic [16:0]                  rec_pos;
	logic [9:0]                   rec_next;
	logic [8:0]                   len_i;
	logic                         out_free;
	logic                         out_load;
	dnc_pkg::result_t             out_d;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;

	// Appending happens for a raw request or for each emitted name byte.
	assign append      = (accept && !item.kind) || (state_q == ST_EM_GET);
	assign append_byte = (state_q == ST_EM_GET) ? em_byte : item.data_byte;
	assign st_we       = append && (32'(msg_len_q) < dnc_pkg::STORE_DEPTH);

	assign nm_we = accept && item.kind && (32'(name_cnt_q) < dnc_pkg::NAME_BYTES);

	assign cur_pos  = sel_q ? pb_q : pa_q;
	assign cur_addr = (state_q == ST_C_PRD) ? {1'b0, cur_pos} + 17'd1 : {1'b0, cur_pos};
	assign ok_d     = sel_q ? (32'(cur_addr) < dnc_pkg::STORE_DEPTH)
	                        : (cur_addr < {8'b0, name_cnt_q});
	assign rd_byte  = ok_q ? (sel_q ? st_rdata : nm_rdata) : 8'h00;
	assign cur_llen = sel_q ? lb_q : la_q;

	always_comb begin
		case (state_q)
			ST_SR_RD: nm_raddr = i_q[7:0];
			ST_EM_RD: nm_raddr = j_q[7:0];
			ST_RC_RD: nm_raddr = j_q[7:0];
			default:  nm_raddr = cur_addr[7:0];
		endcase
	end

	always_comb begin
		if (j_q < {1'b0, k_q}) begin
			em_byte = nm_rdata;
		end else if (j_q == {1'b0, k_q}) begin
			em_byte = {2'b11, ent_pos_q[13:8]};
		end else begin
			em_byte = ent_pos_q[7:0];
		end
	end

	assign skip_i   = i_q + {2'b0, (state_q == ST_SR_GET) ? nm_rdata : lab_q} + 10'd1;
	assign len_i    = name_cnt_q - i_q[8:0];
	assign rec_pos  = {1'b0, off_q} + {7'b0, j_q};
	assign rec_next = j_q + {2'b0, nm_rdata} + 10'd1;

	assign sf_we    = (state_q == ST_RC_GET) && (nm_rdata != 8'h00)
	                  && (rec_pos <= dnc_pkg::POINTER_LIMIT)
	                  && (32'(tcount_q) < dnc_pkg::SUFFIX_ENTRIES);
	assign sf_wdata = {8'(name_cnt_q - j_q[8:0]), rec_pos[13:0]};

	always_comb begin
		out_load = 1'b0;
		out_d    = '0;
		if ((accept && !item.kind) || state_q == ST_RAW) begin
			out_load            = out_free;
			out_d.out_bytes     = {56'b0, (state_q == ST_RAW) ? raw_q : item.data_byte};
			out_d.out_count     = 4'd1;
			out_d.out_last      = 1'b1;
		end else if (state_q == ST_FLUSH) begin
			out_load            = out_free;
			out_d.out_bytes     = word_q;
			out_d.out_count     = cnt_q;
			out_d.out_last      = flast_q;
			out_d.out_matched   = found_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			msg_len_q  <= '0;
			name_cnt_q <= '0;
			tcount_q   <= '0;
			e_q        <= '0;
			raw_q      <= '0;
			cmp_q      <= 1'b0;
			found_q    <= 1'b0;
			i_q        <= '0;
			lab_q      <= '0;
			ent_pos_q  <= '0;
			tgt_q      <= '0;
			kk_q       <= '0;
			pa_q       <= '0;
			pb_q       <= '0;
			la_q       <= '0;
			lb_q       <= '0;
			sel_q      <= 1'b0;
			hops_q     <= '0;
			ptrb_q     <= '0;
			ba_q       <= '0;
			ok_q       <= 1'b0;
			j_q        <= '0;
			k_q        <= '0;
			n_q        <= '0;
			end_q      <= '0;
			off_q      <= '0;
			word_q     <= '0;
			cnt_q      <= '0;
			flast_q    <= 1'b0;
		end else begin
			ok_q <= ok_d;
			if (append && msg_len_q != 16'hFFFF) begin
				msg_len_q <= msg_len_q + 16'd1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!item.kind) begin
							raw_q <= item.data_byte;
							if (!out_free) begin
								state_q <= ST_RAW;
							end
						end else begin
							if (nm_we) begin
								name_cnt_q <= name_cnt_q + 9'd1;
							end
							if (item.last) begin
								cmp_q   <= item.compress;
								found_q <= 1'b0;
								i_q     <= '0;
								state_q <= ST_SR_RD;
							end
						end
					end
				end
				ST_RAW: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SR_RD: state_q <= ST_SR_GET;
				ST_SR_GET: begin
					if (nm_rdata == 8'h00) begin
						i_q <= i_q + 10'd1;
						state_q <= (i_q + 10'd1 < {1'b0, name_cnt_q}) ? ST_SR_RD : ST_SR_DONE;
					end else begin
						lab_q   <= nm_rdata;
						e_q     <= '0;
						state_q <= (tcount_q == '0) ? ST_E_NEXT : ST_E_RD;
					end
				end
				ST_E_RD: state_q <= ST_E_GET;
				ST_E_GET: begin
					if ({1'b0, sf_rdata[21:14]} != len_i) begin
						state_q <= ST_E_NEXT;
					end else begin
						ent_pos_q <= sf_rdata[13:0];
						tgt_q     <= len_i;
						kk_q      <= '0;
						pa_q      <= {6'b0, i_q};
						pb_q      <= {2'b0, sf_rdata[13:0]};
						la_q      <= '0;
						lb_q      <= '0;
						sel_q     <= 1'b0;
						hops_q    <= '0;
						state_q   <= ST_C_RD;
					end
				end
				ST_E_NEXT: begin
					// Try the next entry, or skip past this label once all have failed.
					if (e_q + 1'b1 < tcount_q) begin
						e_q     <= e_q + 1'b1;
						state_q <= ST_E_RD;
					end else begin
						i_q     <= skip_i;
						state_q <= (skip_i < {1'b0, name_cnt_q}) ? ST_SR_RD : ST_SR_DONE;
					end
				end
				ST_C_RD: state_q <= ST_C_CHK;
				ST_C_CHK: begin
					if (cur_llen == 8'h00 && rd_byte[7:6] == 2'b11) begin
						if (hops_q >= dnc_pkg::HOP_LIMIT) begin
							state_q <= ST_E_NEXT;
						end else begin
							ptrb_q  <= rd_byte[5:0];
							state_q <= ST_C_PRD;
						end
					end else if (!sel_q) begin
						ba_q    <= rd_byte;
						la_q    <= (la_q == 8'h00) ? rd_byte : la_q - 8'd1;
						sel_q   <= 1'b1;
						hops_q  <= '0;
						state_q <= ST_C_RD;
					end else begin
						lb_q <= (lb_q == 8'h00) ? rd_byte : lb_q - 8'd1;
						if (fold(ba_q) != fold(rd_byte)) begin
							state_q <= ST_E_NEXT;
						end else if (kk_q + 9'd1 == tgt_q) begin
							found_q <= 1'b1;
							state_q <= ST_SR_DONE;
						end else begin
							pa_q    <= pa_q + 16'd1;
							pb_q    <= pb_q + 16'd1;
							kk_q    <= kk_q + 9'd1;
							sel_q   <= 1'b0;
							hops_q  <= '0;
							state_q <= ST_C_RD;
						end
					end
				end
				ST_C_PRD: state_q <= ST_C_PGET;
				ST_C_PGET: begin
					if (sel_q) begin
						pb_q <= {2'b0, ptrb_q, rd_byte};
					end else begin
						pa_q <= {2'b0, ptrb_q, rd_byte};
					end
					hops_q  <= hops_q + 7'd1;
					state_q <= ST_C_RD;
				end
				ST_SR_DONE: begin
					if (i_q < {1'b0, name_cnt_q}) begin
						end_q <= i_q[8:0];
						k_q   <= cmp_q ? i_q[8:0] : name_cnt_q;
						n_q   <= (cmp_q ? i_q[8:0] : name_cnt_q)
						         + ((cmp_q && found_q) ? 9'd2 : 9'd0);
					end else begin
						end_q <= name_cnt_q;
						k_q   <= name_cnt_q;
						n_q   <= name_cnt_q;
					end
					off_q   <= msg_len_q;
					j_q     <= '0;
					word_q  <= '0;
					cnt_q   <= '0;
					state_q <= ST_EM_RD;
				end
				ST_EM_RD: state_q <= ST_EM_GET;
				ST_EM_GET: begin
					word_q[{cnt_q[2:0], 3'b000} +: 8] <= em_byte;
					cnt_q   <= cnt_q + 4'd1;
					j_q     <= j_q + 10'd1;
					flast_q <= (j_q + 10'd1 == {1'b0, n_q});
					if (cnt_q == 4'd7 || j_q + 10'd1 == {1'b0, n_q}) begin
						state_q <= ST_FLUSH;
					end else begin
						state_q <= ST_EM_RD;
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						word_q <= '0;
						cnt_q  <= '0;
						if (!flast_q) begin
							state_q <= ST_EM_RD;
						end else begin
							j_q <= '0;
							if (end_q == 9'd0) begin
								name_cnt_q <= '0;
								state_q    <= ST_IDLE;
							end else begin
								state_q <= ST_RC_RD;
							end
						end
					end
				end
				ST_RC_RD: state_q <= ST_RC_GET;
				ST_RC_GET: begin
					if (nm_rdata == 8'h00) begin
						j_q <= j_q + 10'd1;
						if (j_q + 10'd1 < {1'b0, end_q}) begin
							state_q <= ST_RC_RD;
						end else begin
							name_cnt_q <= '0;
							state_q    <= ST_IDLE;
						end
					end else if (rec_pos > dnc_pkg::POINTER_LIMIT) begin
						name_cnt_q <= '0;
						state_q    <= ST_IDLE;
					end else begin
						if (sf_we) begin
							tcount_q <= tcount_q + 1'b1;
						end
						j_q <= rec_next;
						if (rec_next < {1'b0, end_q}) begin
							state_q <= ST_RC_RD;
						end else begin
							name_cnt_q <= '0;
							state_q    <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	dnc_ram #(.WIDTH(8), .DEPTH(dnc_pkg::STORE_DEPTH)) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (msg_len_q[dnc_pkg::STORE_AW-1:0]),
		.wdata (append_byte),
		.raddr (cur_addr[dnc_pkg::STORE_AW-1:0]),
		.rdata (st_rdata)
	);

	dnc_ram #(.WIDTH(8), .DEPTH(256)) u_name (
		.clk   (clk),
		.we    (nm_we),
		.waddr (name_cnt_q[7:0]),
		.wdata (item.data_byte),
		.raddr (nm_raddr),
		.rdata (nm_rdata)
	);

	dnc_ram #(.WIDTH(dnc_pkg::SUF_W), .DEPTH(dnc_pkg::SUFFIX_ENTRIES)) u_suffix (
		.clk   (clk),
		.we    (sf_we),
		.waddr (tcount_q[dnc_pkg::SE_AW-1:0]),
		.wdata (sf_wdata),
		.raddr (e_q[dnc_pkg::SE_AW-1:0]),
		.rdata (sf_rdata)
	);

	dnc_outreg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (out_load),
		.load_data (out_d),
		.free      (out_free),
		.valid     (result_valid),
		.stall     (result_stall),
		.data      (result)
	);

endmodule

FILE: sv/dnc_checker.sv
// Port-level checker for the DNS name compressor, bound to the top level.
// Depends on dnc_pkg and dns_name_compressor.
`timescale 1ns / 1ps

module dnc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_stall,
	input logic             result_valid,
	input logic             result_stall,
	input dnc_pkg::result_t result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result request changed");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.out_count != 4'd0 && result.out_count <= 4'd8)
		else $error("result byte count out of range");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.out_last |-> result.out_count == 4'd8)
		else $error("partial result that is not the last");

	a_ready: assert property (@(posedge clk) $rose(arst_n) |-> !item_stall)
		else $error("block not ready after reset");

endmodule

bind dns_name_compressor dnc_checker u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

FILE: test/tb_dns_name_compressor.sv
// Testbench for dns_name_compressor: a directed table, then random names and raw bytes,
// each result checked against the table or a behavioral renderer. Depends on dnc_pkg and dns_name_compressor.
`timescale 1ns / 1ps

module tb_dns_name_compressor;

	localparam int unsigned CYCLE_LIMIT = 3000000;
	localparam int unsigned RANDOM_ITEMS = 95;

	typedef struct {
		dnc_pkg::item_t   req;
		bit               typed;
		dnc_pkg::result_t res;
	} stim_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_stall;
	dnc_pkg::item_t   item = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	dnc_pkg::result_t result;

	// Behavioral copy of the renderer state.
	logic [7:0]  msg_mem [dnc_pkg::STORE_DEPTH];
	int unsigned msg_len;
	logic [7:0]  name_buf [256];
	int unsigned name_len;
	logic [13:0] suf_pos [dnc_pkg::SUFFIX_ENTRIES];
	int unsigned suf_len [dnc_pkg::SUFFIX_ENTRIES];
	int unsigned suf_cnt;

	dnc_pkg::result_t rendered_q[$];
	dnc_pkg::result_t new_results[$];
	stim_row_t        dir_rows[$];
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned tx_idle_pct = 35;
	int unsigned rx_idle_pct = 35;
	int unsigned sent = 0;

	dns_name_compressor i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic int unsigned read_mem(bit from_name, int unsigned pos);
		if (from_name)
			return (pos < name_len && pos < 256) ? 32'(name_buf[pos]) : 0;
		return (pos < dnc_pkg::STORE_DEPTH) ? 32'(msg_mem[pos]) : 0;
	endfunction

	function automatic int unsigned lower(int unsigned b);
		return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
	endfunction

	// Steps a label cursor, chasing pointers found at a label start.
	function automatic bit next_label_byte(input bit from_name, inout int unsigned pos,
			inout int unsigned llen);
		int unsigned hops;
		int unsigned b;
		hops = 0;
		if (llen == 0) begin
			b = read_mem(from_name, pos);
			while ((b & 8'hC0) == 8'hC0) begin
				if (hops >= dnc_pkg::HOP_LIMIT)
					return 1'b0;
				pos = (b & 8'h3F) * 256 + read_mem(from_name, pos + 1);
				hops++;
				b = read_mem(from_name, pos);
			end
			llen = b;
		end else begin
			llen--;
		end
		return 1'b1;
	endfunction

	function automatic bit suffix_same(int unsigned start, int unsigned len, int unsigned e);
		int unsigned pa, la, pb, lb;
		if (suf_len[e] != len)
			return 1'b0;
		pa = start;
		la = 0;
		pb = 32'(suf_pos[e]);
		lb = 0;
		for (int unsigned k = 0; k < len; k++) begin
			if (!next_label_byte(1'b1, pa, la) || !next_label_byte(1'b0, pb, lb))
				return 1'b0;
			if (lower(read_mem(1'b1, pa)) != lower(read_mem(1'b0, pb)))
				return 1'b0;
			pa = (pa + 1) & 16'hFFFF;
			pb = (pb + 1) & 16'hFFFF;
		end
		return 1'b1;
	endfunction

	function automatic void append_msg(logic [7:0] b);
		if (msg_len < dnc_pkg::STORE_DEPTH)
			msg_mem[msg_len] = b;
		if (msg_len < 65535)
			msg_len++;
	endfunction

	function automatic void reset_renderer();
		foreach (msg_mem[k]) msg_mem[k] = '0;
		foreach (name_buf[k]) name_buf[k] = '0;
		foreach (suf_pos[k]) begin
			suf_pos[k] = '0;
			suf_len[k] = 0;
		end
		msg_len = 0;
		name_len = 0;
		suf_cnt = 0;
	endfunction

	// Fills new_results with the words the renderer emits for one request.
	function automatic void render_request(dnc_pkg::item_t x);
		logic [7:0]       emit[$];
		int               found;
		int unsigned      len, i, b, fin, offset, upto, j, ptr;
		dnc_pkg::result_t r;
		new_results.delete();
		found = -1;
		if (!x.kind) begin
			emit.push_back(x.data_byte);
			append_msg(x.data_byte);
		end else begin
			if (name_len < dnc_pkg::NAME_BYTES) begin
				name_buf[name_len] = x.data_byte;
				name_len++;
			end
			if (!x.last)
				return;
			len = name_len;
			i = 0;
			while (i < len && found < 0) begin
				b = 32'(name_buf[i]);
				if (b == 0) begin
					i++;
					continue;
				end
				for (int unsigned e = 0; e < suf_cnt && e < dnc_pkg::SUFFIX_ENTRIES; e++) begin
					if (suffix_same(i, len - i, e)) begin
						found = int'(e);
						break;
					end
				end
				if (found < 0)
					i += b + 1;
			end
			fin = (i < len) ? i : len;
			offset = msg_len;
			upto = x.compress ? fin : len;
			for (j = 0; j < upto; j++)
				emit.push_back(name_buf[j]);
			if (x.compress && found >= 0) begin
				ptr = 32'h0000C000 | 32'(suf_pos[found]);
				emit.push_back(ptr[15:8]);
				emit.push_back(ptr[7:0]);
			end
			foreach (emit[k]) append_msg(emit[k]);
			j = 0;
			while (j < fin) begin
				b = 32'(name_buf[j]);
				if (b == 0) begin
					j++;
					continue;
				end
				if (offset + j > dnc_pkg::POINTER_LIMIT)
					break;
				if (suf_cnt < dnc_pkg::SUFFIX_ENTRIES) begin
					suf_pos[suf_cnt] = 14'((offset + j) & dnc_pkg::POINTER_LIMIT);
					suf_len[suf_cnt] = (len - j) & 8'hFF;
					suf_cnt++;
				end
				j += b + 1;
			end
			name_len = 0;
		end
		while (emit.size() > 0) begin
			r = '0;
			r.out_matched = (found >= 0);
			while (r.out_count < 8 && emit.size() > 0) begin
				r.out_bytes[8 * r.out_count +: 8] = emit.pop_front();
				r.out_count++;
			end
			r.out_last = (emit.size() == 0);
			new_results.push_back(r);
		end
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h, expected %h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	always @(posedge clk) begin
		dnc_pkg::result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (rendered_q.size() == 0) begin
					report_mismatch("unexpected result", result.out_bytes, '0);
				end else begin
					want = rendered_q.pop_front();
					if (result.out_bytes !== want.out_bytes)
						report_mismatch("out_bytes", result.out_bytes, want.out_bytes);
					if (result.out_count !== want.out_count)
						report_mismatch("out_count", 64'(result.out_count),
							64'(want.out_count));
					if (result.out_last !== want.out_last)
						report_mismatch("out_last", 64'(result.out_last), 64'(want.out_last));
					if (result.out_matched !== want.out_matched)
						report_mismatch("out_matched", 64'(result.out_matched),
							64'(want.out_matched));
				end
			end
			result_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	task automatic send_request(dnc_pkg::item_t x, bit typed = 1'b0,
			dnc_pkg::result_t res = '0);
		while ($urandom_range(99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= x;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		render_request(x);
		if (typed)
			rendered_q.push_back(res);
		else
			foreach (new_results[k]) rendered_q.push_back(new_results[k]);
		sent++;
	endtask

	function automatic dnc_pkg::item_t mk(bit kind, logic [7:0] d, bit comp = 1'b1,
			bit last = 1'b0);
		dnc_pkg::item_t x;
		x.kind = kind;
		x.data_byte = d;
		x.compress = comp;
		x.last = last;
		return x;
	endfunction

	function automatic void add_row(dnc_pkg::item_t x, bit typed = 1'b0,
			logic [63:0] bytes = '0, logic [3:0] count = '0, bit matched = 1'b0);
		stim_row_t row;
		row.req = x;
		row.typed = typed;
		row.res.out_bytes = bytes;
		row.res.out_count = count;
		row.res.out_last = 1'b1;
		row.res.out_matched = matched;
		dir_rows.push_back(row);
	endfunction

	function automatic logic [7:0] random_case(logic [7:0] c);
		return $urandom_range(1) ? (c & 8'hDF) : c;
	endfunction

	// Builds a name from a small label pool so that suffixes repeat often.
	task automatic send_random_name();
		string       pool[6] = '{"com", "org", "example", "www", "mail", "a"};
		logic [7:0]  bytes[$];
		int unsigned nlab, ln, cut;
		string       s;
		bit          comp;
		nlab = $urandom_range(0, 3);
		for (int unsigned l = 0; l < nlab; l++) begin
			if ($urandom_range(3) == 0) begin
				ln = $urandom_range(1, 8);
				bytes.push_back(8'(ln));
				for (int unsigned k = 0; k < ln; k++)
					bytes.push_back(8'($urandom_range(0, 255)));
			end else begin
				s = pool[$urandom_range(0, 5)];
				bytes.push_back(8'(s.len()));
				for (int k = 0; k < s.len(); k++)
					bytes.push_back(random_case(s[k]));
			end
		end
		// A truncated name leaves a label length that runs past the end.
		if (bytes.size() > 2 && $urandom_range(9) == 0) begin
			cut = $urandom_range(1, 2);
			repeat (cut) void'(bytes.pop_back());
		end
		bytes.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(0, 8'hBF)) : 8'h00);
		comp = ($urandom_range(3) != 0);
		foreach (bytes[k]) begin
			if ($urandom_range(19) == 0)
				send_request(mk(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(1)),
					1'($urandom_range(1))));
			send_request(mk(1'b1, bytes[k], (k == bytes.size() - 1) ? comp :
				1'($urandom_range(1)), k == bytes.size() - 1));
		end
	endtask

	initial begin
		reset_renderer();
		add_row(mk(1'b0, 8'h00, 1'b0, 1'b0), 1'b1, 64'h00, 4'd1);
		add_row(mk(1'b0, 8'hFF, 1'b1, 1'b1), 1'b1, 64'hFF, 4'd1);
		add_row(mk(1'b1, 8'h03));
		add_row(mk(1'b1, "a"));
		add_row(mk(1'b1, "b"));
		add_row(mk(1'b1, "c"));
		add_row(mk(1'b1, 8'h00, 1'b1, 1'b1), 1'b1, 64'h00_63_62_61_03, 4'd5);
		add_row(mk(1'b1, 8'h03, 1'b0));
		add_row(mk(1'b1, "A", 1'b0));
		add_row(mk(1'b1, "B", 1'b0));
		add_row(mk(1'b1, "C", 1'b0));
		add_row(mk(1'b1, 8'h00, 1'b1, 1'b1), 1'b1, 64'h02_C0, 4'd2, 1'b1);
		add_row(mk(1'b1, 8'h03));
		add_row(mk(1'b1, "a"));
		add_row(mk(1'b1, "B"));
		add_row(mk(1'b1, "c"));
		add_row(mk(1'b1, 8'h00, 1'b0, 1'b1), 1'b1, 64'h00_63_42_61_03, 4'd5, 1'b1);
		// A name that is only the root label never matches.
		add_row(mk(1'b1, 8'h00, 1'b1, 1'b1), 1'b1, 64'h00, 4'd1);
		add_row(mk(1'b1, 8'h05));
		add_row(mk(1'b1, 8'hC7));
		add_row(mk(1'b1, 8'h00, 1'b1, 1'b1));
		// Raw byte in the middle of a name.
		add_row(mk(1'b1, 8'h01));
		add_row(mk(1'b0, 8'h80), 1'b1, 64'h80, 4'd1);
		add_row(mk(1'b1, "q"));
		add_row(mk(1'b1, 8'h00, 1'b1, 1'b1));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k])
			send_request(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].res);

		while (sent < RANDOM_ITEMS) begin
			if (sent > 35 && sent < 70) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else begin
				tx_idle_pct = 35;
				rx_idle_pct = 35;
			end
			if (sent > 75 && sent < 82) begin
				item_valid <= 1'b0;
				do
					@(posedge clk);
				while (rendered_q.size() != 0);
			end
			if ($urandom_range(3) == 0)
				send_request(mk(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(1)),
					1'($urandom_range(1))));
			else
				send_random_name();
		end

		// Overlong name: bytes past the limit are dropped; it also fills the table.
		for (int k = 0; k < 300; k++)
			send_request(mk(1'b1, (k % 2 == 0) ? 8'h01 : "z", 1'b1, k == 299));
		send_random_name();

		item_valid <= 1'b0;
		while (rendered_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && rendered_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
